>>> hw/rtl/mscr_pkg.sv
// Package: shared widths, stage count and control types for the collision response block.
`default_nettype none

package mscr_pkg;

   localparam int VEL_W   = 32;   // Q16.16 velocity
   localparam int NRM_W   = 16;   // Q2.14 normal
   localparam int SHARE_W = 18;   // Q2.16 carry share
   localparam int SCL_W   = 17;   // clamped share, 0..65536
   localparam int REST_W  = 16;   // Q2.14 restitution
   localparam int FAC_W   = 17;   // 1 + restitution, Q.14

   localparam int NUM_AXES   = 3;
   localparam int NUM_STAGES = 8;
   localparam int DLY_STAGES = 6; // stages that carry velocity and normal to the back lane

   localparam logic [SCL_W-1:0] SHARE_ONE = 17'd65536;
   localparam logic [FAC_W-1:0] FAC_ONE   = 17'd16384;

   typedef logic signed [VEL_W-1:0] vel_type;
   typedef logic signed [NRM_W-1:0] nrm_type;
   typedef logic signed [49:0]      dot_term_type;  // rel * normal, Q.30
   typedef logic signed [41:0]      gain_type;      // scaled normal speed, Q26.16

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;   // load enable of each pipeline stage
   } mscr_ctrl_type;

endpackage

`default_nettype wire

>>> hw/rtl/mscr_if.sv
// Interfaces: request and response channels of the collision response block.
`default_nettype none

interface mscr_req_if
   import mscr_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic signed [VEL_W-1:0]     vel_x;
   logic signed [VEL_W-1:0]     vel_y;
   logic signed [VEL_W-1:0]     vel_z;
   logic signed [NRM_W-1:0]     normal_x;
   logic signed [NRM_W-1:0]     normal_y;
   logic signed [NRM_W-1:0]     normal_z;
   logic signed [VEL_W-1:0]     surface_vel_x;
   logic signed [VEL_W-1:0]     surface_vel_y;
   logic signed [VEL_W-1:0]     surface_vel_z;
   logic signed [SHARE_W-1:0]   carry_share;

   modport source (
      output valid, vel_x, vel_y, vel_z, normal_x, normal_y, normal_z,
             surface_vel_x, surface_vel_y, surface_vel_z, carry_share,
      input  ready
   );
   modport sink (
      input  valid, vel_x, vel_y, vel_z, normal_x, normal_y, normal_z,
             surface_vel_x, surface_vel_y, surface_vel_z, carry_share,
      output ready
   );
endinterface

interface mscr_rsp_if
   import mscr_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic signed [VEL_W-1:0] out_vel_x;
   logic signed [VEL_W-1:0] out_vel_y;
   logic signed [VEL_W-1:0] out_vel_z;
   logic                    approaching;

   modport source (
      output valid, out_vel_x, out_vel_y, out_vel_z, approaching,
      input  ready
   );
   modport sink (
      input  valid, out_vel_x, out_vel_y, out_vel_z, approaching,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/mscr_lane_front.sv
// Front lane: carried surface velocity, relative velocity and its dot product term for one axis.
`default_nettype none

module mscr_lane_front
   import mscr_pkg::*;
(
   input  wire logic              clock,
   input  wire mscr_ctrl_type     ctrl,
   input  wire vel_type           vel,
   input  wire nrm_type           nrm,
   input  wire vel_type           svel,
   input  wire logic [SCL_W-1:0]  share,
   output      dot_term_type      dot_term,
   output      vel_type           vel_dly,
   output      nrm_type           nrm_dly
);

   logic signed [49:0] prod_ff, prod_in;
   logic signed [33:0] rel_ff, rel_in;
   dot_term_type       term_ff, term_in;
   vel_type            v_ff [DLY_STAGES];
   nrm_type            n_ff [DLY_STAGES];

   logic [50:0] carry_rnd;
   logic [32:0] carried;

   always_comb begin
      prod_in   = svel * $signed({1'b0, share});
      carry_rnd = {prod_ff[49], prod_ff} + 51'd32768;
      carried   = carry_rnd[48:16];
      rel_in    = $signed({{2{v_ff[0][VEL_W-1]}}, v_ff[0]} - {carried[32], carried});
      term_in   = rel_ff * n_ff[1];
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         prod_ff <= prod_in;
         v_ff[0] <= vel;
         n_ff[0] <= nrm;
      end
      if (ctrl.en[1]) rel_ff  <= rel_in;
      if (ctrl.en[2]) term_ff <= term_in;
   end

   // hold velocity and normal alongside the arithmetic until the back lane needs them
   for (genvar k = 1; k < DLY_STAGES; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (ctrl.en[k]) begin
            v_ff[k] <= v_ff[k-1];
            n_ff[k] <= n_ff[k-1];
         end
      end
   end

   assign dot_term = term_ff;
   assign vel_dly  = v_ff[DLY_STAGES-1];
   assign nrm_dly  = n_ff[DLY_STAGES-1];

endmodule

`default_nettype wire

>>> hw/rtl/mscr_merge.sv
// Merge stage: sums the lane dot terms, detects approach and scales the normal speed.
`default_nettype none

module mscr_merge
   import mscr_pkg::*;
(
   input  wire logic              clock,
   input  wire mscr_ctrl_type     ctrl,
   input  wire logic [REST_W-1:0] restitution,
   input  wire dot_term_type      dot_term [NUM_AXES],
   output      gain_type          gain,
   output      logic              appr
);

   logic signed [37:0] vn_ff, vn_in;
   logic signed [55:0] tp_ff, tp_in;
   gain_type           gain_ff, gain_in;
   logic [2:0]         appr_ff;
   logic               appr_in;

   logic [51:0]      dot;
   logic [51:0]      vn_rnd;
   logic [FAC_W-1:0] fac;
   logic [56:0]      gain_rnd;

   always_comb begin
      dot = {{2{dot_term[0][49]}}, dot_term[0]}
          + {{2{dot_term[1][49]}}, dot_term[1]}
          + {{2{dot_term[2][49]}}, dot_term[2]};
      appr_in  = dot[51];
      vn_rnd   = dot + 52'd8192;
      vn_in    = $signed(vn_rnd[51:14]);
      fac      = {1'b0, restitution} + FAC_ONE;
      tp_in    = vn_ff * $signed({1'b0, fac});
      gain_rnd = {tp_ff[55], tp_ff} + 57'd8192;
      gain_in  = $signed(gain_rnd[55:14]);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[3]) begin
         vn_ff      <= vn_in;
         appr_ff[0] <= appr_in;
      end
      if (ctrl.en[4]) begin
         tp_ff      <= tp_in;
         appr_ff[1] <= appr_ff[0];
      end
      if (ctrl.en[5]) begin
         gain_ff    <= gain_in;
         appr_ff[2] <= appr_ff[1];
      end
   end

   assign gain = gain_ff;
   assign appr = appr_ff[2];

endmodule

`default_nettype wire

>>> hw/rtl/mscr_lane_back.sv
// Back lane: normal correction, reflection select and saturation for one axis.
`default_nettype none

module mscr_lane_back
   import mscr_pkg::*;
(
   input  wire logic          clock,
   input  wire mscr_ctrl_type ctrl,
   input  wire vel_type       vel,
   input  wire nrm_type       nrm,
   input  wire gain_type      gain,
   input  wire logic          appr,
   output      vel_type       out_vel
);

   logic signed [57:0] cp_ff, cp_in;
   vel_type            v_ff;
   logic               appr_ff;
   vel_type            out_ff, out_in;

   logic [58:0] corr_rnd;
   logic [44:0] corr;
   logic [45:0] diff;
   vel_type     sat;

   always_comb begin
      cp_in    = nrm * gain;
      corr_rnd = {cp_ff[57], cp_ff} + 59'd8192;
      corr     = corr_rnd[58:14];
      diff     = {{14{v_ff[VEL_W-1]}}, v_ff} - {corr[44], corr};
      // clip to the 32-bit range when the upper bits disagree with the sign
      if (diff[45:31] == {15{diff[45]}}) begin
         sat = $signed(diff[31:0]);
      end else if (diff[45]) begin
         sat = $signed({1'b1, {(VEL_W-1){1'b0}}});
      end else begin
         sat = $signed({1'b0, {(VEL_W-1){1'b1}}});
      end
      out_in = appr_ff ? sat : v_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[6]) begin
         cp_ff   <= cp_in;
         v_ff    <= vel;
         appr_ff <= appr;
      end
      if (ctrl.en[7]) out_ff <= out_in;
   end

   assign out_vel = out_ff;

endmodule

`default_nettype wire

>>> hw/rtl/moving_surface_collision_response_top.sv
// Top level: moving-surface collision response, three axis lanes around a shared merge stage.
// Throughput: one transaction per cycle; a stalled response holds its stage, and bubbles
// further up still fill, so requests keep flowing until all eight stages are full.
// Reset (synchronous, active high) empties the pipeline and sets restitution to 0.
`default_nettype none

module moving_surface_collision_response_top
   import mscr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [REST_W-1:0] csr_wr_data,
   mscr_req_if.sink               req_ch,
   mscr_rsp_if.source             rsp_ch
);

   // Stage map:
   //   0 front: surface velocity times clamped share
   //   1 front: round to carried velocity, subtract from body velocity
   //   2 front: relative velocity times normal
   //   3 merge: sum the three terms, sign gives approach, round normal speed
   //   4 merge: normal speed times (1 + restitution)
   //   5 merge: round to reflection gain
   //   6 back : normal times gain
   //   7 back : round correction, subtract, saturate, select

   logic [REST_W-1:0]     restitution_ff;
   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES-1:0] up_vld;
   logic [NUM_STAGES-1:0] rdy;
   logic [1:0]            appr_ff;
   mscr_ctrl_type         ctrl;

   logic [SCL_W-1:0] share;
   vel_type          vel     [NUM_AXES];
   nrm_type          nrm     [NUM_AXES];
   vel_type          svel    [NUM_AXES];
   dot_term_type     term    [NUM_AXES];
   vel_type          vel_dly [NUM_AXES];
   nrm_type          nrm_dly [NUM_AXES];
   vel_type          out_vel [NUM_AXES];
   gain_type         gain;
   logic             appr;

   // Configuration register: take the write whenever enabled
   always_ff @(posedge clock) begin
      if (reset) begin
         restitution_ff <= '0;
      end else if (csr_wr_en) begin
         restitution_ff <= csr_wr_data;
      end
   end

   // Flow control: a stage loads when it is empty or its content moves on,
   // so a stalled response blocks only the unbroken run of filled stages behind it
   always_comb begin
      up_vld = {vld_ff[NUM_STAGES-2:0], req_ch.valid};
      rdy[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_ch.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      ctrl.en = rdy & up_vld;
      for (int k = 0; k < NUM_STAGES; k++) begin
         vld_in[k] = rdy[k] ? up_vld[k] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Clamp the carry share to 0..1.0; negative shares act as zero
   always_comb begin
      if (req_ch.carry_share[SHARE_W-1]) begin
         share = '0;
      end else if (req_ch.carry_share[SHARE_W-2:0] > SHARE_ONE) begin
         share = SHARE_ONE;
      end else begin
         share = req_ch.carry_share[SCL_W-1:0];
      end
   end

   assign vel[0]  = req_ch.vel_x;
   assign vel[1]  = req_ch.vel_y;
   assign vel[2]  = req_ch.vel_z;
   assign nrm[0]  = req_ch.normal_x;
   assign nrm[1]  = req_ch.normal_y;
   assign nrm[2]  = req_ch.normal_z;
   assign svel[0] = req_ch.surface_vel_x;
   assign svel[1] = req_ch.surface_vel_y;
   assign svel[2] = req_ch.surface_vel_z;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_front
      mscr_lane_front u_front (
         .clock    (clock),
         .ctrl     (ctrl),
         .vel      (vel[a]),
         .nrm      (nrm[a]),
         .svel     (svel[a]),
         .share    (share),
         .dot_term (term[a]),
         .vel_dly  (vel_dly[a]),
         .nrm_dly  (nrm_dly[a])
      );
   end

   mscr_merge u_merge (
      .clock       (clock),
      .ctrl        (ctrl),
      .restitution (restitution_ff),
      .dot_term    (term),
      .gain        (gain),
      .appr        (appr)
   );

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_back
      mscr_lane_back u_back (
         .clock   (clock),
         .ctrl    (ctrl),
         .vel     (vel_dly[a]),
         .nrm     (nrm_dly[a]),
         .gain    (gain),
         .appr    (appr),
         .out_vel (out_vel[a])
      );
   end

   // Advance the approach flag through the back-lane stages for the response
   always_ff @(posedge clock) begin
      if (ctrl.en[6]) appr_ff[0] <= appr;
      if (ctrl.en[7]) appr_ff[1] <= appr_ff[0];
   end

   assign req_ch.ready       = rdy[0];
   assign rsp_ch.valid       = vld_ff[NUM_STAGES-1];
   assign rsp_ch.out_vel_x   = out_vel[0];
   assign rsp_ch.out_vel_y   = out_vel[1];
   assign rsp_ch.out_vel_z   = out_vel[2];
   assign rsp_ch.approaching = appr_ff[1];

   // An accepted request always lands in the first stage
   a_accept_loads : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> vld_ff[0])
      else $error("accepted transaction did not enter stage 0");

   // A full pipeline with a stalled response must refuse requests
   a_full_blocks : assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request taken while pipeline full and stalled");

   // A stalled response keeps its transaction
   a_stall_keeps : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> rsp_ch.valid)
      else $error("stalled response dropped");

   // A filled stage 3 that cannot move keeps its transaction
   a_mid_hold : assert property (@(posedge clock) disable iff (reset)
      (vld_ff[3] && !rdy[3]) |=> vld_ff[3])
      else $error("merge stage lost a transaction under stall");

endmodule

`default_nettype wire
